// ----- design/double_ended_queue_defines.svh -----
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// Assertion macros used by the double_ended_queue design file.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define DEQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// The condition holds in the cycle after the trigger.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Constants, operation codes and types of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 3;

    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FILL = 2'b10
    } state_t;

endpackage

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words held in a circular single-port store.
// ----------------------------------------------------------------------------
// Usage: each beat on the input channel (in_valid/in_ready) carries an op
// and a data word; each yields exactly one beat on the output channel
// (out_valid/out_ready) with the popped word, the new count, empty flag,
// the front and back words and the overflow flag.
// The front and back words are kept in registers, so a push, a query, a
// failed pop or a pop that leaves at most one word needs no store read: its
// result goes at the accepting edge into the output register, or into the
// skid register if the output register still holds an untaken result. A pop
// that leaves two or more words goes through ST_FILL: the new end word is
// fetched through the store's registered read port, and the result is loaded
// in the cycle after the accepting edge. The deque takes one item per cycle
// while out_ready is high, but none while a pop waits in ST_FILL. A skid
// register lets one more item be accepted while a result waits to be taken;
// a longer stall on out_ready holds in_ready low. Reset empties the deque at
// once; the store is not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [deq_pkg::OP_W-1:0]         op,
    input  logic signed [deq_pkg::WORD_W-1:0] data_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [deq_pkg::WORD_W-1:0] popped_value,
    output logic                             pop_ok,
    output logic [$clog2(DEPTH+1)-1:0]       count_after,
    output logic                             is_empty,
    output logic signed [deq_pkg::WORD_W-1:0] front_value,
    output logic signed [deq_pkg::WORD_W-1:0] back_value,
    output logic                             overflow
);

    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = AW + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W     = deq_pkg::WORD_W;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);

    typedef struct packed {
        logic signed [W-1:0] popped;
        logic                pop_ok;
        logic [CNT_W-1:0]    count;
        logic                empty;
        logic signed [W-1:0] front;
        logic signed [W-1:0] back;
        logic                ovf;
    } res_t;

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CNT_W-1:0] off);
        logic [SW-1:0] s;
        s = {1'b0, base} + SW'(off);
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    // Store and its registered read port
    logic [W-1:0]        store_mem [DEPTH];
    logic signed [W-1:0] rd_data_reg;

    deq_pkg::state_t     state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic signed [W-1:0] front_reg, front_next;
    logic signed [W-1:0] back_reg, back_next;
    logic signed [W-1:0] popped_reg, popped_next;
    logic                fill_front_reg, fill_front_next;

    res_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    res_t skid_reg, skid_next;
    logic skid_valid_reg, skid_valid_next;

    // Decoded effect of the item on the input port
    logic [AW-1:0]       n_head, n_addr, head_inc, head_dec, end_addr;
    logic [CNT_W-1:0]    n_count, end_off;
    logic signed [W-1:0] n_front, n_back, n_popped;
    logic                n_pop_ok, n_ovf, n_read, n_wr, n_fill_front;
    logic                is_full, is_void;

    logic in_accept, wr_en, rd_en, res_valid;
    res_t res_data;

    assign in_ready  = (state_reg == deq_pkg::ST_IDLE) && !skid_valid_reg;
    assign in_accept = in_valid && in_ready;

    assign head_inc = (head_reg == LAST_A) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_A : head_reg - 1'b1;
    assign end_off  = (op == deq_pkg::OP_PUSH_BACK) ? count_reg : count_reg - CNT_W'(2);
    assign end_addr = wrap_add(head_reg, end_off);
    assign is_full  = (count_reg == DEPTH_C);
    assign is_void  = (count_reg == '0);

    always_comb
    begin
        n_head       = head_reg;
        n_count      = count_reg;
        n_front      = front_reg;
        n_back       = back_reg;
        n_popped     = '0;
        n_pop_ok     = 1'b0;
        n_ovf        = 1'b0;
        n_read       = 1'b0;
        n_wr         = 1'b0;
        n_fill_front = 1'b1;
        n_addr       = head_reg;
        unique case (op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    n_ovf = 1'b1;
                end
                else
                begin
                    n_head  = head_dec;
                    n_addr  = head_dec;
                    n_wr    = 1'b1;
                    n_count = count_reg + 1'b1;
                    n_front = data_in;
                    if (is_void)
                    begin
                        n_back = data_in;
                    end
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    n_ovf = 1'b1;
                end
                else
                begin
                    n_addr  = end_addr;
                    n_wr    = 1'b1;
                    n_count = count_reg + 1'b1;
                    n_back  = data_in;
                    if (is_void)
                    begin
                        n_front = data_in;
                    end
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (!is_void)
                begin
                    n_pop_ok = 1'b1;
                    n_popped = front_reg;
                    n_head   = head_inc;
                    n_count  = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        n_front = '0;
                        n_back  = '0;
                    end
                    else if (count_reg == CNT_W'(2))
                    begin
                        n_front = back_reg;
                    end
                    else
                    begin
                        // The new front word lives in the store.
                        n_read = 1'b1;
                        n_addr = head_inc;
                    end
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (!is_void)
                begin
                    n_pop_ok = 1'b1;
                    n_popped = back_reg;
                    n_count  = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        n_front = '0;
                        n_back  = '0;
                    end
                    else if (count_reg == CNT_W'(2))
                    begin
                        n_back = front_reg;
                    end
                    else
                    begin
                        n_read       = 1'b1;
                        n_addr       = end_addr;
                        n_fill_front = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        popped_next     = popped_reg;
        fill_front_next = fill_front_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        res_valid       = 1'b0;
        res_data        = '{popped: n_popped, pop_ok: n_pop_ok, count: n_count,
                            empty: (n_count == '0), front: n_front, back: n_back,
                            ovf: n_ovf};
        unique case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    head_next       = n_head;
                    count_next      = n_count;
                    front_next      = n_front;
                    back_next       = n_back;
                    popped_next     = n_popped;
                    fill_front_next = n_fill_front;
                    wr_en           = n_wr;
                    rd_en           = n_read;
                    if (n_read)
                    begin
                        state_next = deq_pkg::ST_FILL;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
            end
            deq_pkg::ST_FILL:
            begin
                res_valid  = 1'b1;
                state_next = deq_pkg::ST_IDLE;
                if (fill_front_reg)
                begin
                    front_next = rd_data_reg;
                end
                else
                begin
                    back_next = rd_data_reg;
                end
                res_data = '{popped: popped_reg, pop_ok: 1'b1, count: count_reg,
                             empty: 1'b0, front: front_next, back: back_next,
                             ovf: 1'b0};
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res_data;
                skid_valid_next = res_valid;
            end
            else
            begin
                out_next       = res_data;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[n_addr] <= data_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[n_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= deq_pkg::ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            front_reg      <= '0;
            back_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            front_reg      <= front_next;
            back_reg       <= back_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg     <= popped_next;
        fill_front_reg <= fill_front_next;
        out_reg        <= out_next;
        skid_reg       <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_reg.popped;
    assign pop_ok       = out_reg.pop_ok;
    assign count_after  = out_reg.count;
    assign is_empty     = out_reg.empty;
    assign front_value  = out_reg.front;
    assign back_value   = out_reg.back;
    assign overflow     = out_reg.ovf;

    // The skid entry is only ever filled behind a full output register.
    `DEQ_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A pending fetch always has somewhere to put its result.
    `DEQ_ASSERT_IMPL(a_fill_skid_free, state_reg == deq_pkg::ST_FILL, !skid_valid_reg)
    `DEQ_ASSERT_NEXT(a_read_then_fill, in_accept && n_read, state_reg == deq_pkg::ST_FILL)
    // An empty deque must report zero front and back words.
    `DEQ_ASSERT_IMPL(a_empty_zero, count_reg == '0, front_reg == '0 && back_reg == '0)

endmodule
